// ===== hw/rtl/ray_box_slab_test_defines.svh =====
// Assertion macros for the ray box slab test checker.
// Used by the checker file only; no other dependencies.
`ifndef RAY_BOX_SLAB_TEST_DEFINES_SVH
`define RAY_BOX_SLAB_TEST_DEFINES_SVH

// Property on the same cycle: ante implies cons now.
`define RBST_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rbst assertion failed");

// Property on the next cycle: ante implies cons.
`define RBST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rbst assertion failed");

`endif

// ===== hw/rtl/rbst_pkg.sv =====
// Shared types and constants for the ray box slab test.
// No dependencies.
package rbst_pkg;

	localparam int COORD_W  = 32;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int DIST_W   = DIFF_W + COORD_W;
	localparam int NUM_AXES = 3;
	localparam int NUM_REGS = 6;

	// APB data and address layout
	localparam int PDATA_W   = (COORD_W > 32) ? 64 : 32;
	localparam int REG_BYTES = PDATA_W / 8;
	localparam int OFS_W     = $clog2(REG_BYTES);
	localparam int PADDR_W   = $clog2(NUM_REGS * REG_BYTES);
	localparam int IDX_W     = PADDR_W - OFS_W;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [DIST_W-1:0]  dist_t;
	typedef logic [IDX_W-1:0]          reg_idx_t;

	// register indexes
	localparam reg_idx_t REG_MIN_X = IDX_W'(0);
	localparam reg_idx_t REG_MIN_Y = IDX_W'(1);
	localparam reg_idx_t REG_MIN_Z = IDX_W'(2);
	localparam reg_idx_t REG_MAX_X = IDX_W'(3);
	localparam reg_idx_t REG_MAX_Y = IDX_W'(4);
	localparam reg_idx_t REG_MAX_Z = IDX_W'(5);

	typedef struct packed {
		coord_t min_x;
		coord_t min_y;
		coord_t min_z;
		coord_t max_x;
		coord_t max_y;
		coord_t max_z;
	} box_t;

endpackage

// ===== hw/rtl/rbst_cfg.sv =====
// APB register file holding the box bounds.
// Depends on rbst_pkg.
module rbst_cfg
	import rbst_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output box_t               box
);

	box_t     box_q;
	reg_idx_t idx;
	logic     wr_en;
	coord_t   wval;
	coord_t   rval;

	assign idx    = paddr[PADDR_W-1:OFS_W];
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign wval   = coord_t'(pwdata[COORD_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_MIN_X: box_q.min_x <= wval;
				REG_MIN_Y: box_q.min_y <= wval;
				REG_MIN_Z: box_q.min_z <= wval;
				REG_MAX_X: box_q.max_x <= wval;
				REG_MAX_Y: box_q.max_y <= wval;
				REG_MAX_Z: box_q.max_z <= wval;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MIN_X: rval = box_q.min_x;
			REG_MIN_Y: rval = box_q.min_y;
			REG_MIN_Z: rval = box_q.min_z;
			REG_MAX_X: rval = box_q.max_x;
			REG_MAX_Y: rval = box_q.max_y;
			REG_MAX_Z: rval = box_q.max_z;
			default:   rval = '0;
		endcase
	end

	assign prdata = PDATA_W'($unsigned(rval));
	assign box    = box_q;

endmodule

// ===== hw/rtl/rbst_lane.sv =====
// One axis lane: picks near/far planes, subtracts origin, multiplies by inverse.
// Two register stages. Depends on rbst_pkg.
module rbst_lane
	import rbst_pkg::*;
(
	input  logic   clk,
	input  logic   en,
	input  coord_t plane_lo,
	input  coord_t plane_hi,
	input  coord_t origin,
	input  coord_t inv_dir,
	output dist_t  t_near,
	output dist_t  t_far
);

	coord_t near_plane, far_plane;
	diff_t  d_near, d_far;
	diff_t  d_near_s1, d_far_s1;
	coord_t inv_s1;
	dist_t  t_near_s2, t_far_s2;

	// negative inverse direction swaps the planes
	assign near_plane = inv_dir[COORD_W-1] ? plane_hi : plane_lo;
	assign far_plane  = inv_dir[COORD_W-1] ? plane_lo : plane_hi;
	assign d_near     = diff_t'(near_plane) - diff_t'(origin);
	assign d_far      = diff_t'(far_plane) - diff_t'(origin);

	always_ff @(posedge clk) begin
		if (en) begin
			d_near_s1 <= d_near;
			d_far_s1  <= d_far;
			inv_s1    <= inv_dir;
		end
	end

	// full-width signed products, no rounding
	always_ff @(posedge clk) begin
		if (en) begin
			t_near_s2 <= dist_t'(d_near_s1) * dist_t'(inv_s1);
			t_far_s2  <= dist_t'(d_far_s1) * dist_t'(inv_s1);
		end
	end

	assign t_near = t_near_s2;
	assign t_far  = t_far_s2;

endmodule

// ===== hw/rtl/rbst_merge.sv =====
// Merges the three slab intervals into the hit decision over two stages.
// Depends on rbst_pkg.
module rbst_merge
	import rbst_pkg::*;
(
	input  logic  clk,
	input  logic  en,
	input  dist_t t_near [NUM_AXES],
	input  dist_t t_far  [NUM_AXES],
	output logic  hit
);

	logic  ovl_s3;
	dist_t tmin_s3, tmax_s3;
	dist_t zn_s3, zf_s3;
	logic  ovl_z;
	logic  pos;
	logic  hit_s4;

	// x and y intervals, strict compares
	always_ff @(posedge clk) begin
		if (en) begin
			ovl_s3  <= !((t_near[0] > t_far[1]) || (t_near[1] > t_far[0]));
			tmin_s3 <= (t_near[1] > t_near[0]) ? t_near[1] : t_near[0];
			tmax_s3 <= (t_far[0] > t_far[1]) ? t_far[1] : t_far[0];
			zn_s3   <= t_near[2];
			zf_s3   <= t_far[2];
		end
	end

	// z interval; max(tmin, zn) > 0 iff either is positive
	assign ovl_z = !((tmin_s3 > zf_s3) || (zn_s3 > tmax_s3));
	assign pos   = (tmin_s3 > dist_t'(0)) || (zn_s3 > dist_t'(0));

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s4 <= ovl_s3 & ovl_z & pos;
		end
	end

	assign hit = hit_s4;

endmodule

// ===== hw/rtl/ray_box_slab_test.sv =====
// Ray against axis-aligned box slab test, top level; uses rbst_pkg, rbst_cfg,
// rbst_lane and rbst_merge. Each input word is one ray (origin and inverse
// direction, signed fixed point); each output word is one hit bit. The box
// bounds sit in six APB registers at byte offsets 0x00..0x14 (min x, y, z,
// then max x, y, z), written by the user only while no ray is in flight;
// the block does not enforce this. Three axis lanes run side by side:
// stage 1 picks the near/far planes by the sign of the inverse direction and
// subtracts the origin, stage 2 does the full-width multiply, stages 3 and 4
// merge x with y and then z, with strict compares. A ray whose entry distance
// is not strictly positive (origin inside the box) reports no hit. One ray is
// accepted per clock unless stalled and passes four pipeline register stages.
// Stalling a valid output freezes the pipe and sets in_stall in the same cycle.
module ray_box_slab_test
	import rbst_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// input words
	input  logic               in_valid,
	output logic               in_stall,
	input  coord_t             origin_x,
	input  coord_t             origin_y,
	input  coord_t             origin_z,
	input  coord_t             inv_dir_x,
	input  coord_t             inv_dir_y,
	input  coord_t             inv_dir_z,
	// output words
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	// APB register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	box_t  box;
	logic  en;
	logic  v_s1, v_s2, v_s3, v_s4;
	dist_t t_near [NUM_AXES];
	dist_t t_far  [NUM_AXES];

	// pipeline moves unless a finished word is held at the output
	assign en       = !(v_s4 && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	rbst_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.box     (box)
	);

	// one lane per axis
	rbst_lane u_lane_x (
		.clk      (clk),
		.en       (en),
		.plane_lo (box.min_x),
		.plane_hi (box.max_x),
		.origin   (origin_x),
		.inv_dir  (inv_dir_x),
		.t_near   (t_near[0]),
		.t_far    (t_far[0])
	);

	rbst_lane u_lane_y (
		.clk      (clk),
		.en       (en),
		.plane_lo (box.min_y),
		.plane_hi (box.max_y),
		.origin   (origin_y),
		.inv_dir  (inv_dir_y),
		.t_near   (t_near[1]),
		.t_far    (t_far[1])
	);

	rbst_lane u_lane_z (
		.clk      (clk),
		.en       (en),
		.plane_lo (box.min_z),
		.plane_hi (box.max_z),
		.origin   (origin_z),
		.inv_dir  (inv_dir_z),
		.t_near   (t_near[2]),
		.t_far    (t_far[2])
	);

	// interval intersection and final decision
	rbst_merge u_merge (
		.clk    (clk),
		.en     (en),
		.t_near (t_near),
		.t_far  (t_far),
		.hit    (hit)
	);

	assign out_valid = v_s4;

endmodule

// ===== hw/rtl/rbst_checker.sv =====
// Port-level checker for ray_box_slab_test, bound to the top level.
// Depends on rbst_pkg and ray_box_slab_test_defines.svh.
`include "ray_box_slab_test_defines.svh"

module rbst_checker
	import rbst_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic               hit,
	input logic               pready
);

	// a held output word keeps its value
	`RBST_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(hit))

	// input only backs up behind a held output word
	`RBST_ASSERT_NOW(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)

	// a word accepted with no stall after it comes out once it has passed the pipeline
	`RBST_ASSERT_NEXT(a_latency, clk, arst_n, (in_valid && !in_stall) ##1 !in_stall ##1 !in_stall ##1 !in_stall, out_valid)

	// register port never waits
	`RBST_ASSERT_NOW(a_pready, clk, arst_n, 1'b1, pready)

endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (.*);

// ===== dv/ray_box_slab_checker.sv =====
`timescale 1ns / 1ps
// Checker for the ray box slab test: watches the ray, hit and APB channels,
// predicts each hit bit from its own copy of the box and compares in order.
// Depends on rbst_pkg for the coordinate, distance and register index types.
module ray_box_slab_checker
	import rbst_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  coord_t             origin_x,
	input  coord_t             origin_y,
	input  coord_t             origin_z,
	input  coord_t             inv_dir_x,
	input  coord_t             inv_dir_y,
	input  coord_t             inv_dir_z,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               hit,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output int                 errors,
	output int                 pending
);

	box_t box;
	bit   hits_due[$];
	bit   due;
	int   words_out;

	assign pending = hits_due.size();

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	// entry/exit distance on one axis, full product width, no rounding
	function automatic void slab_span(input coord_t lo, input coord_t hi, input coord_t org,
			input coord_t inv, output dist_t t_in, output dist_t t_out);
		diff_t lo_w, hi_w, org_w, near_w, far_w;
		lo_w   = lo;
		hi_w   = hi;
		org_w  = org;
		near_w = (inv[COORD_W-1] ? hi_w : lo_w) - org_w;
		far_w  = (inv[COORD_W-1] ? lo_w : hi_w) - org_w;
		t_in   = near_w * inv;
		t_out  = far_w * inv;
	endfunction

	function automatic bit ray_enters_box(input box_t b, input coord_t ox, input coord_t oy,
			input coord_t oz, input coord_t ix, input coord_t iy, input coord_t iz);
		dist_t t_lo, t_hi, t_in, t_out;
		bit    enters;
		enters = 1'b0;
		slab_span(b.min_x, b.max_x, ox, ix, t_lo, t_hi);
		slab_span(b.min_y, b.max_y, oy, iy, t_in, t_out);
		if (!(t_lo > t_out || t_in > t_hi)) begin
			if (t_in > t_lo)
				t_lo = t_in;
			if (t_hi > t_out)
				t_hi = t_out;
			slab_span(b.min_z, b.max_z, oz, iz, t_in, t_out);
			if (!(t_lo > t_out || t_in > t_hi)) begin
				if (t_in > t_lo)
					t_lo = t_in;
				enters = (t_lo > 0);
			end
		end
		return enters;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box = '0;
			hits_due.delete();
			errors = 0;
			words_out = 0;
		end else begin
			if (out_valid && !out_stall) begin
				words_out++;
				if (hits_due.size() == 0) begin
					report_mismatch($sformatf("hit word %0d with nothing outstanding", words_out));
				end else begin
					due = hits_due.pop_front();
					if (hit !== due)
						report_mismatch($sformatf("hit word %0d: got %b, want %b",
							words_out, hit, due));
				end
			end
			if (in_valid && !in_stall)
				hits_due.push_back(ray_enters_box(box, origin_x, origin_y, origin_z,
					inv_dir_x, inv_dir_y, inv_dir_z));
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr >> OFS_W))
					REG_MIN_X: box.min_x = pwdata[COORD_W-1:0];
					REG_MIN_Y: box.min_y = pwdata[COORD_W-1:0];
					REG_MIN_Z: box.min_z = pwdata[COORD_W-1:0];
					REG_MAX_X: box.max_x = pwdata[COORD_W-1:0];
					REG_MAX_Y: box.max_y = pwdata[COORD_W-1:0];
					REG_MAX_Z: box.max_z = pwdata[COORD_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the ray box slab test bench: clock, reset, ray and APB stimulus, verdict.
// Depends on rbst_pkg, the ray_box_slab_test block and ray_box_slab_checker.
module testbench;
	import rbst_pkg::*;

	// Q16.16 constants and saturated inverses (stand-in for a zero direction)
	localparam coord_t   ONE          = 32'sh0001_0000;
	localparam coord_t   SAT_P        = 32'sh7fff_ffff;
	localparam coord_t   SAT_N        = 32'sh8000_0000;
	// first index past the six box registers; writes there must be dropped
	localparam reg_idx_t REG_SPARE    = reg_idx_t'(REG_MAX_Z + 1);
	// pipeline is four stages deep; give it a little margin after draining
	localparam int       DRAIN_CYCLES = 8;
	// cycles without any handshake before we call it hung
	localparam int       STALL_LIMIT  = 3000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	coord_t             origin_x, origin_y, origin_z;
	coord_t             inv_dir_x, inv_dir_y, inv_dir_z;
	logic               out_valid;
	logic               out_stall;
	logic               hit;
	logic               psel, penable, pwrite, pready;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata, prdata;

	int     errors, pending;
	int     tx_idle_pct, rx_idle_pct, hold_left;
	int     idle_cycles;
	// our own view of the box, only used to aim rays at it
	coord_t box_lo[3], box_hi[3];

	ray_box_slab_test dut (.*);
	ray_box_slab_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Hit side: random stalls, or a long hold-off when hold_left is loaded.
	// The hold-off lets the pipeline fill so in_stall has to back up.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	// Watchdog: reset, any ray or hit handshake, or an APB select resets the count.
	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// APB write: setup cycle, then access cycle until pready. Called at negedge.
	task automatic write_reg(input reg_idx_t idx, input coord_t val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, OFS_W'(0)};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_MIN_X: box_lo[0] = val;
			REG_MIN_Y: box_lo[1] = val;
			REG_MIN_Z: box_lo[2] = val;
			REG_MAX_X: box_hi[0] = val;
			REG_MAX_Y: box_hi[1] = val;
			REG_MAX_Z: box_hi[2] = val;
			default: ;
		endcase
		// bus idle before the next transfer
		@(negedge clk);
	endtask

	task automatic load_box(input coord_t lx, input coord_t ly, input coord_t lz,
			input coord_t hx, input coord_t hy, input coord_t hz);
		write_reg(REG_MIN_X, lx);
		write_reg(REG_MIN_Y, ly);
		write_reg(REG_MIN_Z, lz);
		write_reg(REG_MAX_X, hx);
		write_reg(REG_MAX_Y, hy);
		write_reg(REG_MAX_Z, hz);
	endtask

	// One ray word. Entered at a negedge, returns at the negedge after the
	// word was taken. Valid drops only during sender idle gaps.
	task automatic send_ray(input coord_t ox, input coord_t oy, input coord_t oz,
			input coord_t ix, input coord_t iy, input coord_t iz);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		origin_x  <= ox;
		origin_y  <= oy;
		origin_z  <= oz;
		inv_dir_x <= ix;
		inv_dir_y <= iy;
		inv_dir_z <= iz;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Stop offering rays and wait until every hit has come back.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic longint pick(input longint a, input longint b);
		longint unsigned w;
		w = b - a + 1;
		return a + longint'({$urandom, $urandom} % w);
	endfunction

	function automatic coord_t sat32(input longint v);
		if (v > 64'sd2147483647)
			return SAT_P;
		if (v < -64'sd2147483648)
			return SAT_N;
		return coord_t'(v);
	endfunction

	// Random ray: a quarter pure noise, some starting inside the box, the rest
	// aimed at a target point, mostly inside the box, from an origin around it;
	// the inverse is 1/d in Q16.16 (saturated for d = 0 or at random, rarely zero).
	task automatic random_ray(output coord_t o[3], output coord_t iv[3]);
		longint lo, hi, span, t, org, d;
		int     kind;
		kind = $urandom_range(99);
		for (int a = 0; a < 3; a++) begin
			lo   = (box_lo[a] < box_hi[a]) ? box_lo[a] : box_hi[a];
			hi   = (box_lo[a] < box_hi[a]) ? box_hi[a] : box_lo[a];
			span = hi - lo + ONE;
			if (kind < 25) begin
				o[a]  = $urandom;
				iv[a] = $urandom;
			end else if (kind < 35) begin
				o[a]  = sat32(pick(lo, hi));
				iv[a] = sat32(pick(-16 * ONE, 16 * ONE));
			end else begin
				t   = ($urandom_range(3) != 0) ? pick(lo, hi) : pick(lo - span, hi + span);
				org = sat32(t + pick(-2 * span, 2 * span));
				d   = t - org;
				if (d == 0 || $urandom_range(19) == 0)
					iv[a] = $urandom_range(1) ? SAT_P : SAT_N;
				else if ($urandom_range(29) == 0)
					iv[a] = '0;
				else
					iv[a] = sat32(64'sh1_0000_0000 / d);
				o[a] = coord_t'(org);
			end
		end
	endtask

	initial begin
		coord_t o[3], iv[3];
		int     n_rays;

		// everything known from time zero, reset held low at the start
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		origin_x    = '0;
		origin_y    = '0;
		origin_z    = '0;
		inv_dir_x   = '0;
		inv_dir_y   = '0;
		inv_dir_z   = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_left   = 0;
		for (int a = 0; a < 3; a++) begin
			box_lo[a] = '0;
			box_hi[a] = '0;
		end
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int ph = 0; ph < 6; ph++) begin
			// box per phase; only written here, with the pipe empty
			case (ph)
				0: load_box(-8 * ONE, -4 * ONE, -2 * ONE, 8 * ONE, 4 * ONE, 6 * ONE);
				1: load_box(SAT_N, SAT_N, SAT_N, SAT_P, SAT_P, SAT_P);
				2: begin
					// x slab inverted, z slab flat
					load_box(5 * ONE, -3 * ONE, ONE, -5 * ONE, 3 * ONE, ONE);
					write_reg(REG_SPARE, 32'sh1234_5678);
				end
				3: load_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
				4: load_box(1, 1, 1, 3, 2, 5);
				default: load_box('0, '0, '0, '0, '0, '0);
			endcase

			// idle mix: sender light / receiver heavy, then swapped, then none
			tx_idle_pct = (ph < 2) ? 32 : (ph < 4) ? 64 : 0;
			rx_idle_pct = (ph < 2) ? 64 : (ph < 4) ? 32 : 0;

			if (ph == 0) begin
				// box x [-8,8], y [-4,4], z [-2,6]
				send_ray('0, '0, '0, '0, '0, '0);
				send_ray(-16 * ONE, '0, ONE, ONE, SAT_P, SAT_P);   // straight in along +x
				send_ray(16 * ONE, '0, ONE, -ONE, SAT_N, SAT_N);   // straight in along -x
				send_ray(16 * ONE, '0, ONE, ONE, SAT_P, SAT_P);    // heading away
				send_ray(-16 * ONE, 10 * ONE, ONE, ONE, SAT_P, SAT_P); // misses in y
				send_ray(-16 * ONE, '0, 20 * ONE, ONE, SAT_P, SAT_P);  // misses in z
				send_ray('0, '0, ONE, ONE, ONE, ONE);              // origin inside
				send_ray(-8 * ONE, '0, ONE, ONE, SAT_P, SAT_P);    // origin on the face
				send_ray(-16 * ONE, -16 * ONE, -16 * ONE, ONE, ONE, ONE); // diagonal
				send_ray(-16 * ONE, '0, ONE, '0, SAT_P, SAT_P);    // zero inverse on x
				send_ray(-16 * ONE, 2 * ONE, ONE, 32'sh0000_8000, '0, SAT_N);
				send_ray(SAT_P, SAT_P, SAT_P, SAT_P, SAT_P, SAT_P);
				send_ray(SAT_N, SAT_N, SAT_N, SAT_N, SAT_N, SAT_N);
				send_ray(SAT_N, SAT_P, SAT_N, SAT_P, SAT_N, SAT_P);
				send_ray(SAT_P, SAT_N, SAT_P, SAT_N, SAT_P, SAT_N);
				send_ray(-1, -1, -1, -1, -1, -1);
				send_ray(1, 1, 1, 1, 1, 1);
			end

			case (ph)
				0:       n_rays = 280;
				1, 2, 3: n_rays = 250;
				default: n_rays = 200;
			endcase
			for (int i = 0; i < n_rays; i++) begin
				// long hit-side hold-off while rays keep coming: fills the pipe
				if (ph == 4 && i == 60)
					hold_left = 400;
				// sender pauses until every outstanding hit is back
				if (ph == 5 && i == 100)
					settle();
				random_ray(o, iv);
				send_ray(o[0], o[1], o[2], iv[0], iv[1], iv[2]);
			end
			settle();
		end

		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
